// File: rtl/core/ppdw_pkg.sv
// Shared constants, codes and types of the packed pixel plotter.
`timescale 1ns / 1ps
`default_nettype none

package ppdw_pkg;

    localparam int MAX_SIDE     = 1024;
    localparam int BUFFER_BYTES = 131072;
    localparam int MEM_AW       = $clog2(BUFFER_BYTES);

    localparam int COORD_W    = 11;                 // panel coordinates and sizes
    localparam int IN_COORD_W = 12;                 // signed logical coordinates
    localparam int CALC_W     = 14;                 // room for mirror arithmetic
    localparam int PROD_W     = 2 * COORD_W;        // y * width + x
    localparam int ADDR_W     = 17;                 // byte_address field
    localparam int BYTE_IDX_W = 20;                 // byte index wide enough for any store
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    localparam logic [COORD_W-1:0] SIDE_RST = COORD_W'(MAX_SIDE);

    // transform_mode bit positions
    localparam int MODE_SWAP     = 0;
    localparam int MODE_MIRROR_X = 1;
    localparam int MODE_MIRROR_Y = 2;

    typedef enum logic [1:0] {
        OP_PLOT        = 2'd0,
        OP_CLEAR_DIRTY = 2'd1,
        OP_READ        = 2'd2,
        OP_WRITE       = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PANEL_WIDTH  = 3'd0,
        REG_PANEL_HEIGHT = 3'd1,
        REG_TRANSFORM    = 3'd2,
        REG_CLIP_ENABLE  = 3'd3,
        REG_CLIP_X_MIN   = 3'd4,
        REG_CLIP_Y_MIN   = 3'd5,
        REG_CLIP_X_END   = 3'd6,
        REG_CLIP_Y_END   = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_MUL,
        ST_READ,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] panel_width;
        logic [COORD_W-1:0] panel_height;
        logic [2:0]         transform_mode;
        logic               clip_enable;
        logic [COORD_W-1:0] clip_x_min;
        logic [COORD_W-1:0] clip_y_min;
        logic [COORD_W-1:0] clip_x_end;
        logic [COORD_W-1:0] clip_y_end;
    } cfg_t;

    typedef struct packed {
        logic               ok;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } map_t;

    typedef struct packed {
        logic in_ready;
        logic map_load;
        logic mul_load;
        logic rd_en;
        logic commit;
    } ctrl_t;

    typedef struct packed {
        logic [5:0]              pad;
        logic [7:0]              store_byte;
        logic [ADDR_W-1:0]       byte_address;
        logic                    color_bit;
        logic [IN_COORD_W-1:0]   pos_y;
        logic [IN_COORD_W-1:0]   pos_x;
    } in_data_t;

    typedef struct packed {
        logic [2:0]         pad;
        logic [COORD_W-1:0] dirty_y_high;
        logic [COORD_W-1:0] dirty_y_low;
        logic [COORD_W-1:0] dirty_x_high;
        logic [COORD_W-1:0] dirty_x_low;
        logic [7:0]         read_byte;
        logic               pixel_drawn;
    } out_data_t;

endpackage

`default_nettype wire

// File: rtl/core/ppdw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ppdw_ram #(
    parameter  int DEPTH = 8,
    parameter  int WIDTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ppdw_xform.sv
// Clip test, axis swap, mirroring and panel bounds check of one pixel.
`timescale 1ns / 1ps
`default_nettype none

module ppdw_xform
    import ppdw_pkg::*;
(
    input  wire cfg_t                   cfg,
    input  wire logic [IN_COORD_W-1:0]  pos_x,
    input  wire logic [IN_COORD_W-1:0]  pos_y,
    output map_t                        map
);

    logic signed [CALC_W-1:0] sx, sy, tx, ty, mx, my;
    logic signed [CALC_W-1:0] w_s, h_s, cx_min, cy_min, cx_end, cy_end;
    logic                     clip_fail;

    always_comb begin
        sx     = {{(CALC_W-IN_COORD_W){pos_x[IN_COORD_W-1]}}, pos_x};
        sy     = {{(CALC_W-IN_COORD_W){pos_y[IN_COORD_W-1]}}, pos_y};
        w_s    = {{(CALC_W-COORD_W){1'b0}}, cfg.panel_width};
        h_s    = {{(CALC_W-COORD_W){1'b0}}, cfg.panel_height};
        cx_min = {{(CALC_W-COORD_W){1'b0}}, cfg.clip_x_min};
        cy_min = {{(CALC_W-COORD_W){1'b0}}, cfg.clip_y_min};
        cx_end = {{(CALC_W-COORD_W){1'b0}}, cfg.clip_x_end};
        cy_end = {{(CALC_W-COORD_W){1'b0}}, cfg.clip_y_end};

        // clip applies to the logical coordinate, before any transform
        clip_fail = cfg.clip_enable &&
                    ((sx < cx_min) || (sx >= cx_end) || (sy < cy_min) || (sy >= cy_end));

        tx = cfg.transform_mode[MODE_SWAP] ? sy : sx;
        ty = cfg.transform_mode[MODE_SWAP] ? sx : sy;
        mx = cfg.transform_mode[MODE_MIRROR_X] ? (w_s - tx - CALC_W'(1)) : tx;
        my = cfg.transform_mode[MODE_MIRROR_Y] ? (h_s - ty - CALC_W'(1)) : ty;

        map.ok = !clip_fail && (mx >= 0) && (my >= 0) && (mx < w_s) && (my < h_s);
        map.x  = mx[COORD_W-1:0];
        map.y  = my[COORD_W-1:0];
    end

endmodule

`default_nettype wire

// File: rtl/core/packed_pixel_plot_dirty_window_core.sv
// Top level: request sequencer, frame memory read-modify-write and dirty rectangle.
// Path from input accept to result valid: map, multiply, memory read, write.
// One request at a time: a new request is accepted only after the four stages of the last one;
// the write stage holds for as long as the previous result is still unread.
// A finished result waits in the output register while the next request is accepted.
// Reset: clears control, configuration and dirty rectangle; frame memory is not initialised.
`timescale 1ns / 1ps
`default_nettype none

module packed_pixel_plot_dirty_window_core
    import ppdw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // request stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tdata: pos_x[11:0], pos_y[23:12], color_bit[24], byte_address[41:25], store_byte[49:42]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]            s_tuser,
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // tdata: pixel_drawn[0], read_byte[8:1], dirty_x_low[19:9], dirty_x_high[30:20],
    //        dirty_y_low[41:31], dirty_y_high[52:42]
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    cfg_t       cfg_reg;
    state_t     state_reg, state_next;
    ctrl_t      ctrl;
    in_data_t   in_d;

    op_t                   op_reg;
    logic [IN_COORD_W-1:0] x_reg, y_reg;
    logic                  color_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [7:0]            wbyte_reg;

    map_t                  map_comb, map_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     pos;
    logic [BYTE_IDX_W-1:0] byte_ext, addr_ext;
    logic                  plot_in_store, addr_ok;
    logic [MEM_AW-1:0]     ram_addr, waddr_reg;
    logic                  hit_reg, addr_ok_reg;
    logic [2:0]            bit_reg;

    logic [7:0]            ram_rdata, ram_wdata, mask;
    logic                  ram_we;
    logic                  out_free;

    logic [COORD_W-1:0]    dl_reg, dr_reg, dt_reg, db_reg;
    logic [COORD_W-1:0]    dl_next, dr_next, dt_next, db_next;
    logic [COORD_W:0]      x_inc, y_inc;

    out_data_t             out_reg, out_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    assign in_d     = in_data_t'(s_tdata);
    assign s_tready = ctrl.in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(out_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.panel_width    <= SIDE_RST;
            cfg_reg.panel_height   <= SIDE_RST;
            cfg_reg.transform_mode <= '0;
            cfg_reg.clip_enable    <= 1'b0;
            cfg_reg.clip_x_min     <= '0;
            cfg_reg.clip_y_min     <= '0;
            cfg_reg.clip_x_end     <= SIDE_RST;
            cfg_reg.clip_y_end     <= SIDE_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_PANEL_WIDTH:  cfg_reg.panel_width    <= cfg_wdata[COORD_W-1:0];
                REG_PANEL_HEIGHT: cfg_reg.panel_height   <= cfg_wdata[COORD_W-1:0];
                REG_TRANSFORM:    cfg_reg.transform_mode <= cfg_wdata[2:0];
                REG_CLIP_ENABLE:  cfg_reg.clip_enable    <= cfg_wdata[0];
                REG_CLIP_X_MIN:   cfg_reg.clip_x_min     <= cfg_wdata[COORD_W-1:0];
                REG_CLIP_Y_MIN:   cfg_reg.clip_y_min     <= cfg_wdata[COORD_W-1:0];
                REG_CLIP_X_END:   cfg_reg.clip_x_end     <= cfg_wdata[COORD_W-1:0];
                REG_CLIP_Y_END:   cfg_reg.clip_y_end     <= cfg_wdata[COORD_W-1:0];
                default:          ;
            endcase
        end
    end

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_MAP;
            ST_MAP:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_READ;
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:  ctrl.in_ready = 1'b1;
            ST_MAP:   ctrl.map_load = 1'b1;
            ST_MUL:   ctrl.mul_load = 1'b1;
            ST_READ:  ctrl.rd_en    = 1'b1;
            ST_WRITE: ctrl.commit   = out_free;
            default:  ctrl = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // capture the request
    always_ff @(posedge aclk) begin
        if (ctrl.in_ready && s_tvalid) begin
            op_reg    <= op_t'(s_tuser);
            x_reg     <= in_d.pos_x;
            y_reg     <= in_d.pos_y;
            color_reg <= in_d.color_bit;
            addr_reg  <= in_d.byte_address;
            wbyte_reg <= in_d.store_byte;
        end
    end

    ppdw_xform u_xform (
        .cfg   (cfg_reg),
        .pos_x (x_reg),
        .pos_y (y_reg),
        .map   (map_comb)
    );

    always_ff @(posedge aclk) begin
        if (ctrl.map_load) begin
            map_reg <= map_comb;
        end
        if (ctrl.mul_load) begin
            prod_reg <= map_reg.y * cfg_reg.panel_width;
        end
    end

    // byte address of the pixel, or the request's own address
    always_comb begin
        pos           = prod_reg + PROD_W'(map_reg.x);
        byte_ext      = BYTE_IDX_W'(pos[PROD_W-1:3]);
        addr_ext      = BYTE_IDX_W'(addr_reg);
        plot_in_store = byte_ext < BYTE_IDX_W'(BUFFER_BYTES);
        addr_ok       = addr_ext < BYTE_IDX_W'(BUFFER_BYTES);
        ram_addr      = (op_reg == OP_PLOT) ? byte_ext[MEM_AW-1:0] : addr_ext[MEM_AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            waddr_reg   <= ram_addr;
            hit_reg     <= map_reg.ok && plot_in_store;
            addr_ok_reg <= addr_ok;
            bit_reg     <= pos[2:0];
        end
    end

    ppdw_ram #(
        .DEPTH (BUFFER_BYTES),
        .WIDTH (8)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr_reg),
        .wdata (ram_wdata),
        .re    (ctrl.rd_en),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // modify and write back, grow or empty the dirty rectangle
    always_comb begin
        mask      = 8'h80 >> bit_reg;
        ram_wdata = (op_reg == OP_PLOT) ?
                    (color_reg ? (ram_rdata | mask) : (ram_rdata & ~mask)) : wbyte_reg;
        ram_we    = ctrl.commit &&
                    (((op_reg == OP_PLOT) && hit_reg) || ((op_reg == OP_WRITE) && addr_ok_reg));

        x_inc   = {1'b0, map_reg.x} + (COORD_W+1)'(1);
        y_inc   = {1'b0, map_reg.y} + (COORD_W+1)'(1);
        dl_next = dl_reg;
        dr_next = dr_reg;
        dt_next = dt_reg;
        db_next = db_reg;
        if ((op_reg == OP_PLOT) && hit_reg) begin
            if (map_reg.x < dl_reg) dl_next = map_reg.x;
            if (x_inc > {1'b0, dr_reg}) dr_next = x_inc[COORD_W-1:0];
            if (map_reg.y < dt_reg) dt_next = map_reg.y;
            if (y_inc > {1'b0, db_reg}) db_next = y_inc[COORD_W-1:0];
        end else if (op_reg == OP_CLEAR_DIRTY) begin
            dl_next = cfg_reg.panel_width;
            dr_next = '0;
            dt_next = cfg_reg.panel_height;
            db_next = '0;
        end

        out_next              = '0;
        out_next.pixel_drawn  = (op_reg == OP_PLOT) && hit_reg;
        out_next.read_byte    = ((op_reg == OP_READ) && addr_ok_reg) ? ram_rdata : 8'h00;
        out_next.dirty_x_low  = dl_next;
        out_next.dirty_x_high = dr_next;
        out_next.dirty_y_low  = dt_next;
        out_next.dirty_y_high = db_next;

        m_tvalid_next = ctrl.commit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dl_reg       <= SIDE_RST;
            dr_reg       <= '0;
            dt_reg       <= SIDE_RST;
            db_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (ctrl.commit) begin
                dl_reg <= dl_next;
                dr_reg <= dr_next;
                dt_reg <= dt_next;
                db_reg <= db_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTH
    // one request at a time: no second accept right after one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in flight");

    // memory is written only when the result can be loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_WRITE) && out_free)
        else $error("frame memory written outside commit");

    // a drawn pixel leaves a non-empty dirty rectangle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.pixel_drawn) |->
            (out_reg.dirty_x_low < out_reg.dirty_x_high) &&
            (out_reg.dirty_y_low < out_reg.dirty_y_high))
        else $error("drawn pixel with empty dirty rectangle");
`endif

endmodule

`default_nettype wire
